[hdl/vsh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsh_pkg: shared types and constants of the voltage supervisor
// Fault codes, register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package vsh_pkg;

  localparam int SampleWidth = 16;
  localparam int TimeWidth   = 32;
  localparam int StatusWidth = 2;
  localparam int AddrWidth   = 5;
  localparam int DataWidth   = 32;

  localparam logic [StatusWidth-1:0] FAULT_NONE  = 2'd0;
  localparam logic [StatusWidth-1:0] FAULT_UNDER = 2'd1;
  localparam logic [StatusWidth-1:0] FAULT_OVER  = 2'd2;
  localparam logic [StatusWidth-1:0] FAULT_RSVD  = 2'd3;

  localparam logic [AddrWidth-1:0] ADDR_ENABLE = 5'h00;
  localparam logic [AddrWidth-1:0] ADDR_OVER   = 5'h04;
  localparam logic [AddrWidth-1:0] ADDR_UNDER  = 5'h08;
  localparam logic [AddrWidth-1:0] ADDR_HYST   = 5'h0C;
  localparam logic [AddrWidth-1:0] ADDR_DELAY  = 5'h10;

  localparam logic [SampleWidth-1:0] RESET_OVER_MV  = 16'd32000;
  localparam logic [SampleWidth-1:0] RESET_UNDER_MV = 16'd8000;
  localparam logic [SampleWidth-1:0] DEFAULT_HYST_MV = 16'd2000;
  localparam logic [TimeWidth-1:0]   DEFAULT_DELAY_MS = 32'd3000;

  typedef struct packed {
    logic                   monitor_enable;
    logic [SampleWidth-1:0] over_limit_mv;
    logic [SampleWidth-1:0] under_limit_mv;
    logic [SampleWidth-1:0] hysteresis_mv;
    logic [TimeWidth-1:0]   recovery_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [StatusWidth-1:0] supply_status;
    logic                   recovering;
  } result_t;

endpackage

[hdl/vsh_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsh_channels: valid/ready channels of the voltage supervisor
// One channel carries samples in, the other carries status results out.
// ----------------------------------------------------------------------------
interface vsh_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic [vsh_pkg::SampleWidth-1:0]      sample_mv;
  logic [vsh_pkg::TimeWidth-1:0]        time_ms;

  modport source (output valid, output sample_mv, output time_ms, input ready);
  modport sink (input valid, input sample_mv, input time_ms, output ready);
endinterface

interface vsh_status_if;
  logic                                 valid;
  logic                                 ready;
  logic [vsh_pkg::StatusWidth-1:0]      supply_status;
  logic                                 recovering;

  modport source (output valid, output supply_status, output recovering, input ready);
  modport sink (input valid, input supply_status, input recovering, output ready);
endinterface

[hdl/voltage_supervisor_hysteresis_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voltage_supervisor_hysteresis_top: over/under voltage monitor
// Latches over and under voltage faults and clears them after a timed
// recovery with a hysteresis margin, or when monitoring is disabled.
// ----------------------------------------------------------------------------
// Usage:
// Samples (millivolts and a millisecond timestamp) arrive on the sample
// channel; every accepted sample yields exactly one result on the status
// channel, in order. A transfer happens when valid and ready are both high.
// The fault state is updated in the cycle a sample is accepted, and its result
// is registered into the output queue behind any results still waiting.
// One sample can be taken every cycle. Results go through a two-entry output
// queue; the sample channel stays ready while the queue has a free entry, so
// one more sample is taken while a result waits. When the receiver stalls
// and both entries are full, ready drops until a result transfer frees one.
// Synchronous reset empties the queue, clears the fault and recovery state
// and loads the register defaults: enabled, 32000 mV over, 8000 mV under,
// 2000 mV margin and 3000 ms delay. The user must write registers through the
// APB port only while no sample is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module voltage_supervisor_hysteresis_top (
  input  logic                           clk,
  input  logic                           rst,
  vsh_sample_if.sink                     sample,
  vsh_status_if.source                   status,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vsh_pkg::AddrWidth-1:0]  paddr,
  input  logic [vsh_pkg::DataWidth-1:0]  pwdata,
  output logic [vsh_pkg::DataWidth-1:0]  prdata,
  output logic                           pready
);

  vsh_pkg::cfg_t cfg;

  logic [vsh_pkg::StatusWidth-1:0] fault_kind;
  logic [vsh_pkg::StatusWidth-1:0] fault_kind_next;
  logic                            recovery_pending;
  logic                            recovery_pending_next;
  logic [vsh_pkg::TimeWidth-1:0]   recovery_start_ms;
  logic [vsh_pkg::TimeWidth-1:0]   recovery_start_ms_next;

  logic [vsh_pkg::SampleWidth-1:0] hyst;
  logic [vsh_pkg::TimeWidth-1:0]   delay;
  logic signed [17:0]              over_thr;
  logic [16:0]                     under_thr;
  logic [vsh_pkg::TimeWidth-1:0]   elapsed;
  logic                            recover;
  vsh_pkg::result_t                result;

  vsh_pkg::result_t                queue [2];
  logic                            wr_ptr;
  logic                            rd_ptr;
  logic [1:0]                      count;
  logic                            push;
  logic                            pop;

  vsh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign hyst  = (cfg.hysteresis_mv != '0) ? cfg.hysteresis_mv : vsh_pkg::DEFAULT_HYST_MV;
  assign delay = (cfg.recovery_delay_ms != '0) ? cfg.recovery_delay_ms
                                               : vsh_pkg::DEFAULT_DELAY_MS;
  assign over_thr  = $signed({2'b00, cfg.over_limit_mv}) - $signed({2'b00, hyst});
  assign under_thr = {1'b0, cfg.under_limit_mv} + {1'b0, hyst};
  assign elapsed   = sample.time_ms - recovery_start_ms;

  always_comb begin
    if (fault_kind == vsh_pkg::FAULT_OVER) begin
      recover = $signed({2'b00, sample.sample_mv}) < over_thr;
    end else begin
      recover = {1'b0, sample.sample_mv} > under_thr;
    end
  end

  always_comb begin
    fault_kind_next        = fault_kind;
    recovery_pending_next  = recovery_pending;
    recovery_start_ms_next = recovery_start_ms;
    if (!cfg.monitor_enable) begin
      fault_kind_next       = vsh_pkg::FAULT_NONE;
      recovery_pending_next = 1'b0;
    end else if (fault_kind != vsh_pkg::FAULT_NONE) begin
      if (recover) begin
        if (!recovery_pending) begin
          recovery_pending_next  = 1'b1;
          recovery_start_ms_next = sample.time_ms;
        end else if (elapsed >= delay) begin
          fault_kind_next       = vsh_pkg::FAULT_NONE;
          recovery_pending_next = 1'b0;
        end
      end else begin
        recovery_pending_next = 1'b0;
      end
    end else if (sample.sample_mv > cfg.over_limit_mv) begin
      fault_kind_next       = vsh_pkg::FAULT_OVER;
      recovery_pending_next = 1'b0;
    end else if (sample.sample_mv < cfg.under_limit_mv) begin
      fault_kind_next       = vsh_pkg::FAULT_UNDER;
      recovery_pending_next = 1'b0;
    end
  end

  always_comb begin
    unique case (fault_kind_next)
      vsh_pkg::FAULT_OVER:  result.supply_status = vsh_pkg::FAULT_OVER;
      vsh_pkg::FAULT_UNDER: result.supply_status = vsh_pkg::FAULT_UNDER;
      vsh_pkg::FAULT_NONE,
      vsh_pkg::FAULT_RSVD:  result.supply_status = vsh_pkg::FAULT_NONE;
    endcase
    result.recovering = recovery_pending_next;
  end

  assign sample.ready = (count != 2'd2);
  assign push         = sample.valid && sample.ready;
  assign pop          = status.valid && status.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_kind        <= vsh_pkg::FAULT_NONE;
      recovery_pending  <= 1'b0;
      recovery_start_ms <= '0;
    end else if (push) begin
      fault_kind        <= fault_kind_next;
      recovery_pending  <= recovery_pending_next;
      recovery_start_ms <= recovery_start_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign status.valid         = (count != 2'd0);
  assign status.supply_status = queue[rd_ptr].supply_status;
  assign status.recovering    = queue[rd_ptr].recovering;

  // A delivered result never carries the unused fault code.
  a_no_rsvd_status: assert property (@(posedge clk) disable iff (rst)
    status.valid |-> status.supply_status != vsh_pkg::FAULT_RSVD)
    else $error("reserved fault code delivered");

  // Recovery is only reported while a fault is latched.
  a_recover_has_fault: assert property (@(posedge clk) disable iff (rst)
    status.valid && status.recovering |-> status.supply_status != vsh_pkg::FAULT_NONE)
    else $error("recovery reported without a fault");

  // The queue never overflows: a full queue stalls the sample channel.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3 && (count != 2'd2 || !sample.ready))
    else $error("output queue overflow");

  // Disabling clears the latched fault on the next transfer.
  a_disable_clears: assert property (@(posedge clk) disable iff (rst)
    push && !cfg.monitor_enable |=> fault_kind == vsh_pkg::FAULT_NONE && !recovery_pending)
    else $error("fault kept while disabled");

endmodule

[hdl/vsh_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsh_cfg: configuration registers
// APB-style register file holding the enable, limits, margin and delay.
// ----------------------------------------------------------------------------
module vsh_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vsh_pkg::AddrWidth-1:0]  paddr,
  input  logic [vsh_pkg::DataWidth-1:0]  pwdata,
  output logic [vsh_pkg::DataWidth-1:0]  prdata,
  output logic                           pready,
  output vsh_pkg::cfg_t                  cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.monitor_enable    <= 1'b1;
      cfg.over_limit_mv     <= vsh_pkg::RESET_OVER_MV;
      cfg.under_limit_mv    <= vsh_pkg::RESET_UNDER_MV;
      cfg.hysteresis_mv     <= vsh_pkg::DEFAULT_HYST_MV;
      cfg.recovery_delay_ms <= vsh_pkg::DEFAULT_DELAY_MS;
    end else if (wr_en) begin
      case (paddr)
        vsh_pkg::ADDR_ENABLE: cfg.monitor_enable    <= pwdata[0];
        vsh_pkg::ADDR_OVER:   cfg.over_limit_mv     <= pwdata[vsh_pkg::SampleWidth-1:0];
        vsh_pkg::ADDR_UNDER:  cfg.under_limit_mv    <= pwdata[vsh_pkg::SampleWidth-1:0];
        vsh_pkg::ADDR_HYST:   cfg.hysteresis_mv     <= pwdata[vsh_pkg::SampleWidth-1:0];
        vsh_pkg::ADDR_DELAY:  cfg.recovery_delay_ms <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      vsh_pkg::ADDR_ENABLE: prdata = {31'd0, cfg.monitor_enable};
      vsh_pkg::ADDR_OVER:   prdata = {16'd0, cfg.over_limit_mv};
      vsh_pkg::ADDR_UNDER:  prdata = {16'd0, cfg.under_limit_mv};
      vsh_pkg::ADDR_HYST:   prdata = {16'd0, cfg.hysteresis_mv};
      vsh_pkg::ADDR_DELAY:  prdata = cfg.recovery_delay_ms;
      default:              prdata = '0;
    endcase
  end

endmodule
